[rtl/assert_macros.svh]
// Assertion helper macros for the message FIFO RTL.
// Uses the clk and rst_n names of the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// prop must hold at every clock edge out of reset
`define ASSERT_CLK(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// cond must never be true at a clock edge out of reset
`define ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_CLK(lbl, prop)
`define ASSERT_NEVER(lbl, cond)

`endif

`endif

[rtl/bmf_pkg.sv]
// Shared types and constants for the bounded message FIFO.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bmf_pkg;

    localparam int QUEUE_DEPTH   = 64;
    localparam int MESSAGE_BYTES = 512;
    localparam int SLOT_WORDS    = (MESSAGE_BYTES + 7) / 8;

    localparam int OPCODE_W  = 2;
    localparam int DATA_W    = 64;
    localparam int NB_W      = 4;
    localparam int SIZE_W    = 10;
    localparam int COUNT_W   = 7;
    localparam int STATUS_W  = 3;
    localparam int CFG_W     = 10;
    localparam int CFG_IDX_W = 2;
    localparam int WORD_BYTES = DATA_W / 8;

    localparam int SLOT_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int WORD_W = (SLOT_WORDS > 1) ? $clog2(SLOT_WORDS) : 1;
    localparam int MSG_AW = SLOT_W + WORD_W;

    localparam int S_TDATA_W = ((DATA_W + NB_W + SIZE_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((DATA_W + NB_W + SIZE_W + COUNT_W + 1 + 7) / 8) * 8;

    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);

    localparam logic [COUNT_W-1:0] DEPTH_LIMIT = COUNT_W'(QUEUE_DEPTH);
    localparam logic [SIZE_W-1:0]  BYTES_LIMIT = SIZE_W'(MESSAGE_BYTES);
    localparam logic [COUNT_W-1:0] SLOT_WORDS_C = COUNT_W'(SLOT_WORDS);
    localparam logic [NB_W-1:0]    FULL_WORD_NB = NB_W'(WORD_BYTES);

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BYTES = 2'd1;

    typedef enum logic [OPCODE_W-1:0] {
        OP_SEND  = 2'd0,
        OP_RECV  = 2'd1,
        OP_CLOSE = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_CLOSED    = 3'd1,
        ST_FULL      = 3'd2,
        ST_TOO_LARGE = 3'd3,
        ST_EMPTY     = 3'd4,
        ST_TOO_SMALL = 3'd5
    } status_t;

    // one queued piece of work for the back end
    typedef struct packed {
        logic                is_read;
        status_t             status;
        logic [SIZE_W-1:0]   size;
        logic [COUNT_W-1:0]  queued;
        logic                closed;
        logic [SLOT_W-1:0]   slot;
    } cmd_t;

    typedef struct packed {
        status_t             status;
        logic [DATA_W-1:0]   data_word;
        logic [NB_W-1:0]     data_bytes;
        logic [SIZE_W-1:0]   size;
        logic                last;
        logic [COUNT_W-1:0]  queued;
        logic                closed;
    } result_t;

endpackage

`default_nettype wire

[rtl/bmf_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/bmf_front.sv]
// Front end: config registers, send/receive/close bookkeeping, length store.
// Depends on bmf_pkg and bmf_ram.
`timescale 1ns / 1ps
`default_nettype none

module bmf_front (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [bmf_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [bmf_pkg::CFG_W-1:0]              cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  bmf_pkg::opcode_t                       in_op,
    input  logic [bmf_pkg::DATA_W-1:0]             in_word,
    input  logic [bmf_pkg::NB_W-1:0]               in_nbytes,
    input  logic                                   in_final,
    input  logic [bmf_pkg::SIZE_W-1:0]             in_cap,
    output bmf_pkg::cmd_t                          cmd,
    output logic                                   cmd_push,
    input  logic                                   cmd_room,
    input  logic                                   read_done,
    output logic                                   msg_we,
    output logic [bmf_pkg::MSG_AW-1:0]             msg_waddr,
    output logic [bmf_pkg::DATA_W-1:0]             msg_wdata
);

    import bmf_pkg::*;

    typedef enum logic [1:0] {
        FS_RUN    = 2'b01,
        FS_LOOKUP = 2'b10
    } fstate_t;

    fstate_t              state_reg, state_next;
    logic [SLOT_W-1:0]    head_reg, head_next;
    logic [SLOT_W-1:0]    tail_reg, tail_next;
    logic [COUNT_W-1:0]   held_reg, held_next;
    logic                 closed_reg, closed_next;
    logic [COUNT_W-1:0]   fill_words_reg, fill_words_next;
    logic [SIZE_W-1:0]    fill_bytes_reg, fill_bytes_next;
    status_t              reject_reg, reject_next;
    logic [COUNT_W-1:0]   max_count_reg;
    logic [SIZE_W-1:0]    max_bytes_reg;
    logic [SIZE_W-1:0]    cap_reg, cap_next;
    logic [SLOT_W-1:0]    slot_reg, slot_next;
    logic                 pend_reg, pend_next;

    logic                 accept;
    logic [COUNT_W-1:0]   lim_count;
    logic [SIZE_W-1:0]    lim_bytes;
    logic [NB_W-1:0]      nb;
    logic [SIZE_W:0]      sum;
    logic [SIZE_W-1:0]    fill_bytes_sat;
    status_t              rr_first, rr_chk, rr_final;
    logic                 len_we;
    logic [SIZE_W-1:0]    len_rdata;
    logic [SIZE_W-1:0]    size_c;

    // length store, read address tracks the head slot
    bmf_ram #(
        .WIDTH (SIZE_W),
        .DEPTH (2 ** SLOT_W)
    ) u_len_ram (
        .clk   (clk),
        .we    (len_we),
        .waddr (tail_reg),
        .wdata (fill_bytes_sat),
        .re    (1'b1),
        .raddr (head_reg),
        .rdata (len_rdata)
    );

    // nothing is taken while a message read is outstanding, so a send never
    // overwrites a slot the back end still reads
    assign in_ready = (state_reg == FS_RUN) && cmd_room && !pend_reg;
    assign accept   = in_valid && in_ready;

    assign lim_count = (max_count_reg > DEPTH_LIMIT) ? DEPTH_LIMIT : max_count_reg;
    assign lim_bytes = (max_bytes_reg > BYTES_LIMIT) ? BYTES_LIMIT : max_bytes_reg;

    assign nb = (in_final && (in_nbytes >= 4'd1) && (in_nbytes <= FULL_WORD_NB))
                ? in_nbytes : FULL_WORD_NB;

    assign sum = {1'b0, fill_bytes_reg} + (SIZE_W + 1)'(nb);
    assign fill_bytes_sat = sum[SIZE_W] ? '1 : sum[SIZE_W-1:0];

    always_comb
    begin
        if (fill_words_reg == '0)
        begin
            if (closed_reg)
            begin
                rr_first = ST_CLOSED;
            end
            else if (held_reg >= lim_count)
            begin
                rr_first = ST_FULL;
            end
            else
            begin
                rr_first = ST_OK;
            end
        end
        else
        begin
            rr_first = reject_reg;
        end
    end

    assign rr_chk   = ((rr_first == ST_OK) && (sum > {1'b0, lim_bytes})) ? ST_TOO_LARGE
                                                                         : rr_first;
    assign rr_final = ((rr_chk == ST_OK) && closed_reg) ? ST_CLOSED : rr_chk;

    assign msg_waddr = {tail_reg, fill_words_reg[WORD_W-1:0]};
    assign msg_wdata = in_word;

    assign size_c = (len_rdata > BYTES_LIMIT) ? BYTES_LIMIT : len_rdata;

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        held_next       = held_reg;
        closed_next     = closed_reg;
        fill_words_next = fill_words_reg;
        fill_bytes_next = fill_bytes_reg;
        reject_next     = reject_reg;
        cap_next        = cap_reg;
        slot_next       = slot_reg;
        pend_next       = pend_reg;
        cmd_push        = 1'b0;
        msg_we          = 1'b0;
        len_we          = 1'b0;
        cmd             = '0;
        cmd.status      = ST_OK;
        cmd.slot        = slot_reg;

        if (read_done)
        begin
            pend_next = 1'b0;
        end

        case (state_reg)
            FS_RUN:
            begin
                if (accept)
                begin
                    case (in_op)
                        OP_SEND:
                        begin
                            msg_we = (rr_chk == ST_OK) && (fill_words_reg < SLOT_WORDS_C);
                            if (in_final)
                            begin
                                cmd_push        = 1'b1;
                                cmd.status      = rr_final;
                                cmd.size        = fill_bytes_sat;
                                fill_words_next = '0;
                                fill_bytes_next = '0;
                                reject_next     = ST_OK;
                                if (rr_final == ST_OK)
                                begin
                                    len_we    = 1'b1;
                                    held_next = held_reg + 1'b1;
                                    tail_next = (tail_reg == SLOT_W'(QUEUE_DEPTH - 1))
                                                ? '0 : tail_reg + 1'b1;
                                end
                            end
                            else
                            begin
                                fill_bytes_next = fill_bytes_sat;
                                reject_next     = rr_chk;
                                if (fill_words_reg != '1)
                                begin
                                    fill_words_next = fill_words_reg + 1'b1;
                                end
                            end
                        end
                        OP_RECV:
                        begin
                            if (closed_reg)
                            begin
                                cmd_push   = 1'b1;
                                cmd.status = ST_CLOSED;
                            end
                            else if (held_reg == '0)
                            begin
                                cmd_push   = 1'b1;
                                cmd.status = ST_EMPTY;
                            end
                            else
                            begin
                                // size comes out of the length store next cycle
                                slot_next  = head_reg;
                                cap_next   = in_cap;
                                held_next  = held_reg - 1'b1;
                                head_next  = (head_reg == SLOT_W'(QUEUE_DEPTH - 1))
                                             ? '0 : head_reg + 1'b1;
                                state_next = FS_LOOKUP;
                            end
                        end
                        OP_CLOSE:
                        begin
                            closed_next = 1'b1;
                            cmd_push    = 1'b1;
                        end
                        default:
                        begin
                            cmd_push = 1'b1;
                        end
                    endcase
                end
            end
            FS_LOOKUP:
            begin
                state_next = FS_RUN;
                cmd_push   = 1'b1;
                if (cap_reg < len_rdata)
                begin
                    cmd.status = ST_TOO_SMALL;
                    cmd.size   = len_rdata;
                end
                else if (size_c != '0)
                begin
                    cmd.is_read = 1'b1;
                    cmd.size    = size_c;
                    pend_next   = 1'b1;
                end
            end
            default:
            begin
                state_next = FS_RUN;
            end
        endcase

        cmd.queued = held_next;
        cmd.closed = closed_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= FS_RUN;
            head_reg       <= '0;
            tail_reg       <= '0;
            held_reg       <= '0;
            closed_reg     <= 1'b0;
            fill_words_reg <= '0;
            fill_bytes_reg <= '0;
            reject_reg     <= ST_OK;
            max_count_reg  <= DEPTH_LIMIT;
            max_bytes_reg  <= BYTES_LIMIT;
            pend_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            held_reg       <= held_next;
            closed_reg     <= closed_next;
            fill_words_reg <= fill_words_next;
            fill_bytes_reg <= fill_bytes_next;
            reject_reg     <= reject_next;
            pend_reg       <= pend_next;
            if (cfg_we && (cfg_index == CFG_MAX_COUNT))
            begin
                max_count_reg <= cfg_data[COUNT_W-1:0];
            end
            if (cfg_we && (cfg_index == CFG_MAX_BYTES))
            begin
                max_bytes_reg <= cfg_data[SIZE_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cap_reg  <= cap_next;
        slot_reg <= slot_next;
    end

endmodule

`default_nettype wire

[rtl/bmf_cmd_queue.sv]
// Short request queue between the front end and the back end.
// Depends on bmf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bmf_cmd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  bmf_pkg::cmd_t  push_cmd,
    output logic           room,
    input  logic           pop,
    output bmf_pkg::cmd_t  head_cmd,
    output logic           valid
);

    import bmf_pkg::*;

    cmd_t                 ent_reg [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0]   wr_ptr_reg;
    logic [CMDQ_AW-1:0]   rd_ptr_reg;
    logic [CMDQ_AW:0]     cnt_reg;

    assign room     = (cnt_reg != (CMDQ_AW + 1)'(CMDQ_DEPTH));
    assign valid    = (cnt_reg != '0);
    assign head_cmd = ent_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

[rtl/bmf_back.sv]
// Back end: walks queued requests, reads message words, buffers results.
// Depends on bmf_pkg; the message RAM sits outside.
`timescale 1ns / 1ps
`default_nettype none

module bmf_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bmf_pkg::cmd_t                 cmd,
    input  logic                          cmd_valid,
    output logic                          cmd_pop,
    output logic                          read_done,
    output logic                          msg_re,
    output logic [bmf_pkg::MSG_AW-1:0]    msg_raddr,
    input  logic [bmf_pkg::DATA_W-1:0]    msg_rdata,
    output logic                          out_valid,
    input  logic                          out_ready,
    output bmf_pkg::result_t              out_res
);

    import bmf_pkg::*;

    typedef struct packed {
        logic                is_read;
        status_t             status;
        logic [NB_W-1:0]     nb;
        logic [SIZE_W-1:0]   size;
        logic                last;
        logic [COUNT_W-1:0]  queued;
        logic                closed;
    } beat_t;

    function automatic logic [DATA_W-1:0] keep_bytes(input logic [DATA_W-1:0] w,
                                                     input logic [NB_W-1:0] n);
        logic [DATA_W-1:0] m;
        m = '0;
        for (int j = 0; j < WORD_BYTES; j++)
        begin
            if (NB_W'(j) < n)
            begin
                m[j*8 +: 8] = w[j*8 +: 8];
            end
        end
        return m;
    endfunction

    logic                 busy_reg;
    cmd_t                 cur_reg;
    logic [WORD_W-1:0]    idx_reg;
    logic [SIZE_W-1:0]    rem_reg;
    logic                 beat_valid_reg;
    beat_t                beat_reg;
    result_t              ent_reg [2];
    logic                 wr_ptr_reg;
    logic                 rd_ptr_reg;
    logic [1:0]           cnt_reg;

    logic                 pop;
    logic [2:0]           occ;
    logic                 issue;
    logic                 beat_last;
    logic [NB_W-1:0]      beat_nb;
    result_t              land_res;

    assign out_valid = (cnt_reg != '0);
    assign out_res   = ent_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    // a beat issued now lands in the result buffer next cycle; keep a slot for it
    assign occ   = 3'(cnt_reg) + 3'(beat_valid_reg) - 3'(pop);
    assign issue = busy_reg && (occ <= 3'd1);

    assign beat_last = !cur_reg.is_read || (rem_reg <= SIZE_W'(WORD_BYTES));
    assign beat_nb   = (rem_reg > SIZE_W'(WORD_BYTES)) ? FULL_WORD_NB : rem_reg[NB_W-1:0];

    assign cmd_pop   = cmd_valid && (!busy_reg || (issue && beat_last));
    assign read_done = issue && beat_last && cur_reg.is_read;
    assign msg_re    = issue && cur_reg.is_read;
    assign msg_raddr = {cur_reg.slot, idx_reg};

    always_comb
    begin
        land_res.status     = beat_reg.status;
        land_res.data_word  = beat_reg.is_read ? keep_bytes(msg_rdata, beat_reg.nb) : '0;
        land_res.data_bytes = beat_reg.is_read ? beat_reg.nb : '0;
        land_res.size       = beat_reg.size;
        land_res.last       = beat_reg.last;
        land_res.queued     = beat_reg.queued;
        land_res.closed     = beat_reg.closed;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            beat_valid_reg <= 1'b0;
            wr_ptr_reg     <= 1'b0;
            rd_ptr_reg     <= 1'b0;
            cnt_reg        <= '0;
        end
        else
        begin
            beat_valid_reg <= issue;
            if (cmd_pop)
            begin
                busy_reg <= 1'b1;
            end
            else if (issue && beat_last)
            begin
                busy_reg <= 1'b0;
            end
            if (beat_valid_reg)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (beat_valid_reg && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !beat_valid_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            cur_reg <= cmd;
            idx_reg <= '0;
            rem_reg <= cmd.size;
        end
        else if (issue)
        begin
            idx_reg <= idx_reg + 1'b1;
            rem_reg <= rem_reg - SIZE_W'(WORD_BYTES);
        end
        if (issue)
        begin
            beat_reg.is_read <= cur_reg.is_read;
            beat_reg.status  <= cur_reg.status;
            beat_reg.nb      <= beat_nb;
            beat_reg.size    <= cur_reg.size;
            beat_reg.last    <= beat_last;
            beat_reg.queued  <= cur_reg.queued;
            beat_reg.closed  <= cur_reg.closed;
        end
        if (beat_valid_reg)
        begin
            ent_reg[wr_ptr_reg] <= land_res;
        end
    end

endmodule

`default_nettype wire

[rtl/bounded_message_fifo.sv]
// Bounded message FIFO top level: stream ports, config port, message RAM.
// Depends on bmf_pkg, bmf_ram, bmf_front, bmf_cmd_queue, bmf_back, assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

// Queue of variable-length messages held in 64 slots of 512 bytes. Send words
// are taken one per cycle while s_tready is high and written straight into the
// message RAM; the word with tlast ends the message and yields one result. A
// close or a failed receive gives one result. A receive that finds a message
// reads the length store in the front end and then, if its capacity suffices,
// streams ceil(size/8) words out of the message RAM read port at one word per
// cycle while the result buffer has room; no new request is accepted until
// the last word of that message has been read out. A short request queue and
// a two-entry result buffer let the input side keep going while results wait.
// The stores have no reset pass: the block is usable right after reset.
module bounded_message_fifo (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // [63:0] send_word, [67:64] word_bytes, [77:68] receive_capacity
    input  logic [bmf_pkg::S_TDATA_W-1:0]        s_tdata,
    // [1:0] opcode
    input  logic [bmf_pkg::OPCODE_W-1:0]         s_tuser,
    input  logic                                 s_tlast,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [63:0] data_word, [67:64] data_bytes, [77:68] message_size,
    // [84:78] queued_count, [85] closed
    output logic [bmf_pkg::M_TDATA_W-1:0]        m_tdata,
    // [2:0] status
    output logic [bmf_pkg::STATUS_W-1:0]         m_tuser,
    output logic                                 m_tlast,
    input  logic                                 cfg_we,
    input  logic [bmf_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [bmf_pkg::CFG_W-1:0]            cfg_data
);

    import bmf_pkg::*;

    cmd_t                 front_cmd;
    logic                 cmd_push;
    logic                 cmd_room;
    cmd_t                 back_cmd;
    logic                 cmd_valid;
    logic                 cmd_pop;
    logic                 read_done;
    logic                 msg_we;
    logic [MSG_AW-1:0]    msg_waddr;
    logic [DATA_W-1:0]    msg_wdata;
    logic                 msg_re;
    logic [MSG_AW-1:0]    msg_raddr;
    logic [DATA_W-1:0]    msg_rdata;
    result_t              res;

    bmf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (opcode_t'(s_tuser)),
        .in_word   (s_tdata[DATA_W-1:0]),
        .in_nbytes (s_tdata[DATA_W +: NB_W]),
        .in_final  (s_tlast),
        .in_cap    (s_tdata[DATA_W + NB_W +: SIZE_W]),
        .cmd       (front_cmd),
        .cmd_push  (cmd_push),
        .cmd_room  (cmd_room),
        .read_done (read_done),
        .msg_we    (msg_we),
        .msg_waddr (msg_waddr),
        .msg_wdata (msg_wdata)
    );

    bmf_ram #(
        .WIDTH (DATA_W),
        .DEPTH (2 ** MSG_AW)
    ) u_msg_ram (
        .clk   (clk),
        .we    (msg_we),
        .waddr (msg_waddr),
        .wdata (msg_wdata),
        .re    (msg_re),
        .raddr (msg_raddr),
        .rdata (msg_rdata)
    );

    bmf_cmd_queue u_cmdq (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (cmd_push),
        .push_cmd (front_cmd),
        .room     (cmd_room),
        .pop      (cmd_pop),
        .head_cmd (back_cmd),
        .valid    (cmd_valid)
    );

    bmf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (back_cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .read_done (read_done),
        .msg_re    (msg_re),
        .msg_raddr (msg_raddr),
        .msg_rdata (msg_rdata),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    assign m_tdata = {(M_TDATA_W - (DATA_W + NB_W + SIZE_W + COUNT_W + 1))'(0),
                      res.closed, res.queued, res.size, res.data_bytes, res.data_word};
    assign m_tuser = res.status;
    assign m_tlast = res.last;

`include "assert_macros.svh"

    `ASSERT_NEVER(a_cmdq_overflow, cmd_push && !cmd_room)
    `ASSERT_NEVER(a_cmdq_underflow, cmd_pop && !cmd_valid)
    `ASSERT_CLK(a_fail_single,
                m_tvalid && (res.status != ST_OK) |-> res.last && (res.data_bytes == '0))

endmodule

`default_nettype wire

[test/tb_top.sv]
// Self-checking bench for bounded_message_fifo: directed rows, three random phases, end rows.
// A built-in predictor supplies the expected results.
// Depends on bmf_pkg and the bounded_message_fifo RTL.
`timescale 1ns / 1ps

module tb_top;

    import bmf_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 32;
    localparam int SHOWN_ERRORS = 10;

    // unused register indexes, writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    typedef enum {ROW_REQ, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t              kind;
        opcode_t                op;
        logic [DATA_W-1:0]      word;
        logic [NB_W-1:0]        wb;
        logic                   fin;
        logic [SIZE_W-1:0]      cap;
        logic                   typed;
        status_t                st;
        logic [SIZE_W-1:0]      sz;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic [CFG_W-1:0]       reg_val;
    } stim_row_t;

    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic [OPCODE_W-1:0]    s_tuser = '0;
    logic                   s_tlast = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [STATUS_W-1:0]    m_tuser;
    logic                   m_tlast;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_W-1:0]       cfg_data = '0;

    bounded_message_fifo uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state
    logic [DATA_W-1:0]  slot_words_mem [0:QUEUE_DEPTH*SLOT_WORDS-1];
    logic [SIZE_W-1:0]  slot_len_mem [0:QUEUE_DEPTH-1];
    int unsigned        rd_slot = 0;
    int unsigned        wr_slot = 0;
    int unsigned        msgs_held = 0;
    logic               queue_closed = 1'b0;
    int unsigned        part_words = 0;
    int unsigned        part_bytes = 0;
    status_t            part_reject = ST_OK;
    int unsigned        lim_count_reg = 64;
    int unsigned        lim_bytes_reg = 512;

    result_t            owed_replies [$];
    stim_row_t          stim_rows [$];
    result_t            seen;
    result_t            want;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int accepted_requests = 0;
    int checked_results = 0;
    int mismatch_count = 0;
    int cycle_count = 0;
    int status_hits [0:5];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void push_reply(status_t st, logic [DATA_W-1:0] w, logic [NB_W-1:0] nb,
                                       logic [SIZE_W-1:0] sz, logic lst);
        result_t r;
        r.status     = st;
        r.data_word  = w;
        r.data_bytes = nb;
        r.size       = sz;
        r.last       = lst;
        r.queued     = COUNT_W'(msgs_held);
        r.closed     = queue_closed;
        owed_replies.push_back(r);
    endfunction

    function automatic void apply_fifo_request(opcode_t op, logic [DATA_W-1:0] word,
                                               logic [NB_W-1:0] wb, logic fin,
                                               logic [SIZE_W-1:0] cap);
        int unsigned cnt_lim;
        int unsigned byte_lim;
        int unsigned nb;
        int unsigned sum;
        int unsigned slot;
        int unsigned size;
        int unsigned nwords;
        int unsigned rem;
        logic [DATA_W-1:0] w;
        cnt_lim  = (lim_count_reg > QUEUE_DEPTH) ? QUEUE_DEPTH : lim_count_reg;
        byte_lim = (lim_bytes_reg > MESSAGE_BYTES) ? MESSAGE_BYTES : lim_bytes_reg;
        case (op)
            OP_SEND:
            begin
                nb = (fin && wb >= 1 && wb <= 8) ? wb : 8;
                if (part_words == 0)
                begin
                    if (queue_closed)
                        part_reject = ST_CLOSED;
                    else if (msgs_held >= cnt_lim)
                        part_reject = ST_FULL;
                    else
                        part_reject = ST_OK;
                end
                sum = part_bytes + nb;
                if (part_reject == ST_OK)
                begin
                    if (sum > byte_lim)
                        part_reject = ST_TOO_LARGE;
                    else if (part_words < SLOT_WORDS)
                        slot_words_mem[wr_slot * SLOT_WORDS + part_words] = word;
                end
                part_bytes = (sum > 1023) ? 1023 : sum;
                if (part_words < 127)
                    part_words++;
                if (fin)
                begin
                    // a close that came in mid-message still kills it
                    if (part_reject == ST_OK && queue_closed)
                        part_reject = ST_CLOSED;
                    if (part_reject == ST_OK)
                    begin
                        slot_len_mem[wr_slot] = SIZE_W'(part_bytes);
                        wr_slot = (wr_slot + 1) % QUEUE_DEPTH;
                        msgs_held++;
                    end
                    push_reply(part_reject, '0, '0, SIZE_W'(part_bytes), 1'b1);
                    part_words  = 0;
                    part_bytes  = 0;
                    part_reject = ST_OK;
                end
            end
            OP_RECV:
            begin
                if (queue_closed)
                    push_reply(ST_CLOSED, '0, '0, '0, 1'b1);
                else if (msgs_held == 0)
                    push_reply(ST_EMPTY, '0, '0, '0, 1'b1);
                else
                begin
                    slot = rd_slot;
                    size = slot_len_mem[slot];
                    rd_slot = (rd_slot + 1) % QUEUE_DEPTH;
                    msgs_held--;
                    if (cap < size)
                        push_reply(ST_TOO_SMALL, '0, '0, SIZE_W'(size), 1'b1);
                    else
                    begin
                        if (size > MESSAGE_BYTES)
                            size = MESSAGE_BYTES;
                        if (size == 0)
                            push_reply(ST_OK, '0, '0, '0, 1'b1);
                        else
                        begin
                            nwords = (size + 7) / 8;
                            for (int i = 0; i < nwords; i++)
                            begin
                                rem = size - i * 8;
                                nb  = (rem > 8) ? 8 : rem;
                                w   = slot_words_mem[slot * SLOT_WORDS + i];
                                if (nb < 8)
                                    w &= (64'd1 << (nb * 8)) - 64'd1;
                                push_reply(ST_OK, w, NB_W'(nb), SIZE_W'(size), i + 1 == nwords);
                            end
                        end
                    end
                end
            end
            OP_CLOSE:
            begin
                queue_closed = 1'b1;
                push_reply(ST_OK, '0, '0, '0, 1'b1);
            end
            default:
                push_reply(ST_OK, '0, '0, '0, 1'b1);
        endcase
    endfunction

    function automatic void note_mismatch(string what, result_t exp_r, result_t got_r);
        mismatch_count++;
        if (mismatch_count <= SHOWN_ERRORS)
        begin
            $write("[%0t] %s: exp st=%0d w=%h nb=%0d sz=%0d l=%0b q=%0d c=%0b",
                   $time, what, exp_r.status, exp_r.data_word, exp_r.data_bytes, exp_r.size,
                   exp_r.last, exp_r.queued, exp_r.closed);
            $display(" | got st=%0d w=%h nb=%0d sz=%0d l=%0b q=%0d c=%0b",
                     got_r.status, got_r.data_word, got_r.data_bytes, got_r.size,
                     got_r.last, got_r.queued, got_r.closed);
        end
    endfunction

    // result side: random back-pressure, then compare against the oldest owed reply
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        if (rst_n && m_tvalid && m_tready)
        begin
            seen.status     = status_t'(m_tuser);
            seen.data_word  = m_tdata[63:0];
            seen.data_bytes = m_tdata[67:64];
            seen.size       = m_tdata[77:68];
            seen.queued     = m_tdata[84:78];
            seen.closed     = m_tdata[85];
            seen.last       = m_tlast;
            checked_results++;
            if (m_tuser <= 5)
                status_hits[m_tuser]++;
            if (owed_replies.size() == 0)
                note_mismatch("result with none owed", seen, seen);
            else
            begin
                want = owed_replies.pop_front();
                if (seen.status !== want.status || seen.data_word !== want.data_word ||
                    seen.data_bytes !== want.data_bytes || seen.size !== want.size ||
                    seen.last !== want.last || seen.queued !== want.queued ||
                    seen.closed !== want.closed)
                    note_mismatch("mismatch", want, seen);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still owed",
                     cycle_count, owed_replies.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic push_request(opcode_t op, logic [DATA_W-1:0] word, logic [NB_W-1:0] wb,
                                logic fin, logic [SIZE_W-1:0] cap, logic typed,
                                status_t tst, logic [SIZE_W-1:0] tsz);
        int gap;
        result_t r;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tlast  <= fin;
        s_tdata  <= S_TDATA_W'({cap, wb, word});
        do @(posedge clk); while (!s_tready);
        accepted_requests++;
        apply_fifo_request(op, word, wb, fin, cap);
        if (typed)
        begin
            r = owed_replies.pop_back();
            r.status = tst;
            r.size   = tsz;
            owed_replies.push_back(r);
        end
    endtask

    // hold off new requests until every owed result is out, plus some slack
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        while (owed_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        wait_for_drain();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_MAX_COUNT)
            lim_count_reg = val & 127;
        else if (idx == CFG_MAX_BYTES)
            lim_bytes_reg = val;
    endtask

    function automatic void add_req(opcode_t op, logic [DATA_W-1:0] word, logic [NB_W-1:0] wb,
                                    logic fin, logic [SIZE_W-1:0] cap, logic typed,
                                    status_t st, logic [SIZE_W-1:0] sz);
        stim_row_t row;
        row.kind = ROW_REQ;
        row.op = op;
        row.word = word;
        row.wb = wb;
        row.fin = fin;
        row.cap = cap;
        row.typed = typed;
        row.st = st;
        row.sz = sz;
        row.reg_idx = '0;
        row.reg_val = '0;
        stim_rows.push_back(row);
    endfunction

    function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        stim_row_t row;
        row.kind = ROW_CFG;
        row.op = OP_NONE;
        row.word = '0;
        row.wb = '0;
        row.fin = 1'b0;
        row.cap = '0;
        row.typed = 1'b0;
        row.st = ST_OK;
        row.sz = '0;
        row.reg_idx = idx;
        row.reg_val = val;
        stim_rows.push_back(row);
    endfunction

    task automatic walk_rows(int first, int stop);
        for (int i = first; i < stop; i++)
        begin
            if (stim_rows[i].kind == ROW_CFG)
                write_register(stim_rows[i].reg_idx, stim_rows[i].reg_val);
            else
                push_request(stim_rows[i].op, stim_rows[i].word, stim_rows[i].wb,
                             stim_rows[i].fin, stim_rows[i].cap, stim_rows[i].typed,
                             stim_rows[i].st, stim_rows[i].sz);
        end
    endtask

    function automatic logic [NB_W-1:0] pick_final_bytes();
        if ($urandom_range(0, 99) < 85)
            return NB_W'($urandom_range(1, 8));
        // out-of-range counts: 9..15, and 16 wraps to 0
        return NB_W'($urandom_range(9, 16));
    endfunction

    function automatic logic [SIZE_W-1:0] pick_capacity();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return SIZE_W'($urandom_range(512, 1023));
        if (r < 90)
            return SIZE_W'($urandom_range(0, 64));
        return SIZE_W'($urandom_range(0, 1023));
    endfunction

    function automatic int pick_words();
        int unsigned byte_lim;
        int top;
        int r;
        byte_lim = (lim_bytes_reg > MESSAGE_BYTES) ? MESSAGE_BYTES : lim_bytes_reg;
        top = (byte_lim + 7) / 8;
        if (top < 1)
            top = 1;
        r = $urandom_range(0, 99);
        if (r < 55)
            return $urandom_range(1, 2);
        if (r < 85)
            return $urandom_range(3, 8);
        if (r < 95)
            return $urandom_range(1, top + 1);
        return $urandom_range(top, top + 2);
    endfunction

    task automatic random_side_request(opcode_t op, logic [SIZE_W-1:0] cap);
        push_request(op, {$urandom, $urandom}, NB_W'($urandom_range(0, 15)),
                     $urandom_range(0, 1), cap, 1'b0, ST_OK, '0);
    endtask

    // one message as a run of send words; a receive or no-op may slip in between words
    task automatic send_message(int n_words, logic [NB_W-1:0] last_nb);
        int r;
        for (int i = 0; i < n_words; i++)
        begin
            if (i > 0 && $urandom_range(0, 99) < 8)
            begin
                r = $urandom_range(0, 3);
                random_side_request((r == 0) ? OP_NONE : OP_RECV, pick_capacity());
            end
            push_request(OP_SEND, {$urandom, $urandom},
                         (i == n_words - 1) ? last_nb : NB_W'($urandom_range(0, 15)),
                         i == n_words - 1, SIZE_W'($urandom_range(0, 1023)), 1'b0, ST_OK, '0);
        end
    endtask

    task automatic run_phase(int idle_pct, int stall_pct, logic [CFG_W-1:0] count_val,
                             logic [CFG_W-1:0] bytes_val, int n_items, bit with_long);
        int start;
        int r;
        bit paused;
        write_register(CFG_MAX_COUNT, count_val);
        write_register(CFG_MAX_BYTES, bytes_val);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        if (with_long)
        begin
            while (msgs_held != 0)
                random_side_request(OP_RECV, 10'h3FF);
            // a full-size message read back into a buffer that just fits
            send_message(SLOT_WORDS, 4'd8);
            random_side_request(OP_RECV, 10'd512);
        end
        start  = accepted_requests;
        paused = 1'b0;
        while (accepted_requests - start < n_items)
        begin
            if (!paused && accepted_requests - start >= n_items / 2)
            begin
                wait_for_drain();
                paused = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (r < 45)
                send_message(pick_words(), pick_final_bytes());
            else if (r < 88)
                random_side_request(OP_RECV, pick_capacity());
            else
                random_side_request(OP_NONE, pick_capacity());
        end
    endtask

    initial
    begin
        int open_rows;
        for (int i = 0; i <= 5; i++)
            status_hits[i] = 0;

        // directed rows, queue still open
        add_req(OP_RECV, 64'h0, 4'd0, 1'b0, 10'd512, 1'b1, ST_EMPTY, 10'd0);
        add_req(OP_NONE, 64'hFFFF_FFFF_FFFF_FFFF, 4'hF, 1'b1, 10'h3FF, 1'b1, ST_OK, 10'd0);
        add_req(OP_SEND, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1, 10'h3FF, 1'b0, ST_OK, 10'd0);
        add_req(OP_SEND, 64'h0123_4567_89AB_CDEF, 4'd0, 1'b1, 10'd0, 1'b0, ST_OK, 10'd0);
        add_req(OP_SEND, 64'hA5A5_5A5A_0F0F_F0F0, 4'd3, 1'b0, 10'd0, 1'b0, ST_OK, 10'd0);
        add_req(OP_RECV, 64'h0, 4'd0, 1'b0, 10'h3FF, 1'b0, ST_OK, 10'd0);
        add_req(OP_SEND, 64'hDEAD_BEEF_CAFE_F00D, 4'd1, 1'b1, 10'd0, 1'b0, ST_OK, 10'd0);
        add_req(OP_SEND, 64'h8000_0000_0000_0001, 4'hF, 1'b1, 10'd0, 1'b0, ST_OK, 10'd0);
        add_req(OP_RECV, 64'h0, 4'd0, 1'b0, 10'd7, 1'b1, ST_TOO_SMALL, 10'd8);
        add_req(OP_RECV, 64'h0, 4'd0, 1'b0, 10'd9, 1'b0, ST_OK, 10'd0);
        add_cfg(CFG_MAX_COUNT, 10'd0);
        add_req(OP_SEND, 64'h1111_2222_3333_4444, 4'd8, 1'b1, 10'd0, 1'b1, ST_FULL, 10'd8);
        add_cfg(CFG_MAX_COUNT, 10'd1);
        add_req(OP_SEND, 64'h5555_6666_7777_8888, 4'd8, 1'b0, 10'd0, 1'b0, ST_OK, 10'd0);
        add_req(OP_SEND, 64'h9999_AAAA_BBBB_CCCC, 4'd4, 1'b1, 10'd0, 1'b0, ST_OK, 10'd0);
        add_cfg(CFG_MAX_BYTES, 10'd0);
        add_req(OP_RECV, 64'h0, 4'd0, 1'b0, 10'd512, 1'b0, ST_OK, 10'd0);
        add_req(OP_SEND, 64'h0000_0000_0000_00FF, 4'd1, 1'b1, 10'd0, 1'b1, ST_TOO_LARGE, 10'd1);
        add_cfg(CFG_MAX_BYTES, 10'd16);
        add_req(OP_SEND, 64'h0102_0304_0506_0708, 4'd8, 1'b0, 10'd0, 1'b0, ST_OK, 10'd0);
        add_req(OP_SEND, 64'h1112_1314_1516_1718, 4'd8, 1'b0, 10'd0, 1'b0, ST_OK, 10'd0);
        add_req(OP_SEND, 64'h2122_2324_2526_2728, 4'd2, 1'b1, 10'd0, 1'b0, ST_OK, 10'd0);
        add_cfg(CFG_SPARE_LO, 10'h3FF);
        add_cfg(CFG_SPARE_HI, 10'h000);
        add_req(OP_SEND, 64'h3132_3334_3536_3738, 4'd8, 1'b1, 10'd0, 1'b0, ST_OK, 10'd0);
        open_rows = stim_rows.size();

        // rows for the end of the run: the close is permanent
        add_req(OP_SEND, 64'h4142_4344_4546_4748, 4'd5, 1'b1, 10'd0, 1'b0, ST_OK, 10'd0);
        add_req(OP_SEND, 64'h5152_5354_5556_5758, 4'd8, 1'b0, 10'd0, 1'b0, ST_OK, 10'd0);
        add_req(OP_CLOSE, 64'h0, 4'd0, 1'b0, 10'd0, 1'b1, ST_OK, 10'd0);
        add_req(OP_SEND, 64'h6162_6364_6566_6768, 4'd8, 1'b1, 10'd0, 1'b1, ST_CLOSED, 10'd16);
        add_req(OP_RECV, 64'h0, 4'd0, 1'b0, 10'd512, 1'b1, ST_CLOSED, 10'd0);
        add_req(OP_SEND, 64'h7172_7374_7576_7778, 4'd8, 1'b1, 10'd0, 1'b1, ST_CLOSED, 10'd8);
        add_req(OP_CLOSE, 64'h0, 4'd0, 1'b0, 10'd0, 1'b1, ST_OK, 10'd0);
        add_req(OP_NONE, 64'h0, 4'd0, 1'b0, 10'd0, 1'b1, ST_OK, 10'd0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        walk_rows(0, open_rows);
        run_phase(23, 69, 10'd3, 10'd40, 25, 1'b0);
        // count field keeps the low 7 bits (127, above the depth); bytes 1023 is above the slot
        run_phase(69, 23, 10'h3FF, 10'h3FF, 25, 1'b0);
        run_phase(0, 0, 10'd64, 10'd512, 25, 1'b1);
        walk_rows(open_rows, stim_rows.size());
        wait_for_drain();

        $display("%0d requests in, %0d results checked, %0d mismatches",
                 accepted_requests, checked_results, mismatch_count);
        $display("status mix ok/closed/full/too-large/empty/too-small: %0d/%0d/%0d/%0d/%0d/%0d",
                 status_hits[0], status_hits[1], status_hits[2], status_hits[3],
                 status_hits[4], status_hits[5]);
        if (mismatch_count == 0 && owed_replies.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/bmf_pkg.sv
rtl/bmf_ram.sv
rtl/bmf_front.sv
rtl/bmf_cmd_queue.sv
rtl/bmf_back.sv
rtl/bounded_message_fifo.sv
test/tb_top.sv
